// File: src/sliding_window_byte_rate_limiter_assert.svh
// Assertion macros for the rate limiter.
`ifndef SLIDING_WINDOW_BYTE_RATE_LIMITER_ASSERT_SVH
`define SLIDING_WINDOW_BYTE_RATE_LIMITER_ASSERT_SVH

`ifndef SYNTHESIS
`define SWBRL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SWBRL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SWBRL_ASSERT_NOW(label, ante, cons, msg)
`define SWBRL_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: src/swbrl_pkg.sv
package swbrl_pkg;

	localparam int unsigned TICK_W     = 32;
	localparam int unsigned BYTES_W    = 16;
	localparam int unsigned LIMIT_W    = 40;
	localparam int unsigned SHOWN_W    = 22;
	localparam int unsigned CFG_IDX_W  = 8;

	localparam logic [SHOWN_W-1:0] WINDOW_BYTES_MAX = {SHOWN_W{1'b1}};

	localparam logic [TICK_W-1:0]  WINDOW_TICKS_RST     = 32'd1000;
	localparam logic [LIMIT_W-1:0] WINDOW_BIT_LIMIT_RST = 40'd54000000;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS     = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_BIT_LIMIT = 8'd1;

	// result status codes
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_OVER    = 2'd1;
	localparam logic [1:0] STATUS_FULL    = 2'd2;

	typedef struct packed {
		logic [TICK_W-1:0]  now_tick;
		logic [BYTES_W-1:0] byte_count;
	} req_t;

	typedef struct packed {
		logic               accepted;
		logic [1:0]         status;
		logic [SHOWN_W-1:0] window_bytes;
	} rsp_t;

	typedef struct packed {
		logic [TICK_W-1:0]  rec_time;
		logic [BYTES_W-1:0] rec_bytes;
	} record_t;

	typedef enum logic {
		ST_IDLE,
		ST_EVICT
	} state_t;

endpackage

// File: src/sliding_window_byte_rate_limiter.sv
// Sliding-window byte rate limiter. Issue a request (now_tick, byte_count) by raising start
// while busy is low; one result beat follows on rsp, marked by a single-cycle done strobe,
// and it cannot be held off. Records that have aged out of the window are evicted first:
// the records sit in one synchronous memory with a single read port, and eviction walks
// it oldest first, one record per cycle. A record is evicted at most once. busy drops
// in the cycle the result is shown, so the next request may start then. Configuration
// writes (cfg_valid/cfg_ready) are always taken and should only be issued while busy is
// low. Status 1 (over limit) takes priority over status 2 (ring full).
`include "sliding_window_byte_rate_limiter_assert.svh"

module sliding_window_byte_rate_limiter #(
	parameter int unsigned HISTORY_DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  swbrl_pkg::req_t                        req,
	output logic                                   done,
	output swbrl_pkg::rsp_t                        rsp,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [swbrl_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [swbrl_pkg::LIMIT_W-1:0]          cfg_data
);

	localparam int unsigned IW   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int unsigned CW   = $clog2(HISTORY_DEPTH + 1);
	localparam int unsigned SW   = swbrl_pkg::BYTES_W + CW;
	localparam int unsigned CMPW = (SW + 4 > swbrl_pkg::LIMIT_W) ? SW + 4 : swbrl_pkg::LIMIT_W;
	localparam int unsigned SWX  = (SW > swbrl_pkg::SHOWN_W) ? SW : swbrl_pkg::SHOWN_W;

	swbrl_pkg::state_t state_q, state_d;

	logic [swbrl_pkg::TICK_W-1:0]  win_ticks_q;
	logic [swbrl_pkg::LIMIT_W-1:0] win_limit_q;
	logic [IW-1:0]                 oldest_q;
	logic [CW-1:0]                 count_q;
	logic [SW-1:0]                 sum_q;
	swbrl_pkg::req_t               cur_q;
	swbrl_pkg::record_t            rd_q;
	swbrl_pkg::rsp_t               rsp_q;
	logic                          done_q;

	swbrl_pkg::record_t            mem [HISTORY_DEPTH];

	logic                          take;
	logic [swbrl_pkg::TICK_W-1:0]  age;
	logic                          evict_hit;
	logic                          decide;
	logic [IW-1:0]                 oldest_inc;
	logic [IW-1:0]                 rd_addr;
	logic [SW:0]                   total;
	logic                          over;
	logic                          full;
	logic                          accept_ok;
	logic [IW:0]                   slot_sum;
	logic [IW-1:0]                 slot;
	logic [SW-1:0]                 new_sum;
	logic [swbrl_pkg::SHOWN_W-1:0] shown;

	assign take      = start && !busy;
	assign cfg_ready = 1'b1;

	// eviction check and decision
	always_comb begin
		age        = cur_q.now_tick - rd_q.rec_time;
		evict_hit  = (state_q == swbrl_pkg::ST_EVICT) && (count_q != '0) &&
			(age >= win_ticks_q);
		decide     = (state_q == swbrl_pkg::ST_EVICT) && !evict_hit;
		oldest_inc = (oldest_q == IW'(HISTORY_DEPTH - 1)) ? '0 : oldest_q + 1'b1;
		// walk ahead during eviction so the next record is ready in the following cycle
		rd_addr    = evict_hit ? oldest_inc : oldest_q;
		total      = {1'b0, sum_q} + (SW+1)'(cur_q.byte_count);
		over       = (CMPW'(total) << 3) > CMPW'(win_limit_q);
		full       = count_q >= CW'(HISTORY_DEPTH);
		accept_ok  = !over && !full;
		slot_sum   = {1'b0, oldest_q} + (IW+1)'(count_q);
		slot       = (slot_sum >= (IW+1)'(HISTORY_DEPTH)) ?
			IW'(slot_sum - (IW+1)'(HISTORY_DEPTH)) : IW'(slot_sum);
		new_sum    = accept_ok ? total[SW-1:0] : sum_q;
		shown      = (SWX'(new_sum) > SWX'(swbrl_pkg::WINDOW_BYTES_MAX)) ?
			swbrl_pkg::WINDOW_BYTES_MAX : swbrl_pkg::SHOWN_W'(new_sum);
	end

	always_comb begin
		state_d = state_q;
		busy    = 1'b0;
		case (state_q)
			swbrl_pkg::ST_IDLE: begin
				if (start) begin
					state_d = swbrl_pkg::ST_EVICT;
				end
			end
			swbrl_pkg::ST_EVICT: begin
				busy = 1'b1;
				if (decide) begin
					state_d = swbrl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = swbrl_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swbrl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_ticks_q <= swbrl_pkg::WINDOW_TICKS_RST;
			win_limit_q <= swbrl_pkg::WINDOW_BIT_LIMIT_RST;
			oldest_q    <= '0;
			count_q     <= '0;
			sum_q       <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= decide;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					swbrl_pkg::REG_WINDOW_TICKS: begin
						win_ticks_q <= cfg_data[swbrl_pkg::TICK_W-1:0];
					end
					swbrl_pkg::REG_WINDOW_BIT_LIMIT: begin
						win_limit_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end
			if (evict_hit) begin
				sum_q    <= sum_q - SW'(rd_q.rec_bytes);
				oldest_q <= oldest_inc;
				count_q  <= count_q - 1'b1;
			end else if (decide && accept_ok) begin
				sum_q   <= new_sum;
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cur_q <= req;
		end
		if (decide) begin
			rsp_q.accepted     <= accept_ok;
			rsp_q.status       <= over ? swbrl_pkg::STATUS_OVER :
				(full ? swbrl_pkg::STATUS_FULL : swbrl_pkg::STATUS_OK);
			rsp_q.window_bytes <= shown;
		end
	end

	// record memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (decide && accept_ok) begin
			mem[slot] <= {cur_q.now_tick, cur_q.byte_count};
		end
		rd_q <= mem[rd_addr];
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	`SWBRL_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(HISTORY_DEPTH), "record count beyond depth")
	`SWBRL_ASSERT_NOW(a_empty_sum, count_q == '0, sum_q == '0, "empty ring with nonzero byte sum")
	`SWBRL_ASSERT_NEXT(a_start_busy, take, busy && !done, "accepted request did not go busy")
	`SWBRL_ASSERT_NOW(a_done_src, done, $past(state_q) == swbrl_pkg::ST_EVICT, "result without request")

endmodule
